@@ rtl/lbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lbm_pkg;

  localparam int unsigned LED_COUNT = 46;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned END_LEDS  = 15;

  localparam logic [7:0]  PEDAL_MIN   = 8'd51;
  localparam logic [19:0] LVL_TARGET  = 20'd49157;   // clamped 24.0 in Q5.11, plus rounding
  localparam logic [31:0] DIV10_RECIP = 32'd838861;  // ceil(2^23 / 10)
  localparam logic [31:0] LCG_MUL     = 32'd1103515245;
  localparam logic [31:0] LCG_ADD     = 32'd12345;
  localparam logic [31:0] FRAME_GAP   = 32'd10;
  localparam logic [5:0]  LAST_IDX    = 6'd45;

  localparam logic [7:0] GEAR_STRIPE_A = 8'd2;
  localparam logic [7:0] GEAR_STRIPE_B = 8'd5;
  localparam logic [7:0] GEAR_RAND_A   = 8'd3;
  localparam logic [7:0] GEAR_RAND_B   = 8'd6;

  typedef enum logic [1:0] {
    PAT_BANDS,
    PAT_STRIPE,
    PAT_RANDOM
  } pat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LVL_MUL,
    ST_LVL_WR,
    ST_PIX,
    ST_RND_MUL,
    ST_RND_ADD,
    ST_DIM_MUL,
    ST_DIM_WR,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  pedal_byte;
    logic [31:0] now_ms;
    logic [7:0]  gear;
  } in_item_t;

  typedef struct packed {
    logic [5:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // tan(b degrees) in unsigned Q1.16
  function automatic logic [16:0] tan_q16(input logic [5:0] b);
    logic [16:0] t;
    case (b)
      6'd0:  t = 17'd0;     6'd1:  t = 17'd1144;  6'd2:  t = 17'd2289;
      6'd3:  t = 17'd3435;  6'd4:  t = 17'd4583;  6'd5:  t = 17'd5734;
      6'd6:  t = 17'd6888;  6'd7:  t = 17'd8047;  6'd8:  t = 17'd9210;
      6'd9:  t = 17'd10380; 6'd10: t = 17'd11556; 6'd11: t = 17'd12739;
      6'd12: t = 17'd13930; 6'd13: t = 17'd15130; 6'd14: t = 17'd16340;
      6'd15: t = 17'd17560; 6'd16: t = 17'd18792; 6'd17: t = 17'd20036;
      6'd18: t = 17'd21294; 6'd19: t = 17'd22566; 6'd20: t = 17'd23853;
      6'd21: t = 17'd25157; 6'd22: t = 17'd26478; 6'd23: t = 17'd27818;
      6'd24: t = 17'd29179; 6'd25: t = 17'd30560; 6'd26: t = 17'd31964;
      6'd27: t = 17'd33392; 6'd28: t = 17'd34846; 6'd29: t = 17'd36327;
      6'd30: t = 17'd37837; 6'd31: t = 17'd39378; 6'd32: t = 17'd40951;
      6'd33: t = 17'd42560; 6'd34: t = 17'd44205; 6'd35: t = 17'd45889;
      6'd36: t = 17'd47615; 6'd37: t = 17'd49385; 6'd38: t = 17'd51202;
      6'd39: t = 17'd53070; 6'd40: t = 17'd54991; 6'd41: t = 17'd56970;
      6'd42: t = 17'd59009; 6'd43: t = 17'd61113; 6'd44: t = 17'd63287;
      default: t = 17'd65536;
    endcase
    return t;
  endfunction

  // byte-sum folding: 256 == 1 mod 255
  function automatic logic [7:0] mod255(input logic [31:0] s);
    logic [9:0] sum;
    logic [8:0] fold;
    sum  = 10'(s[7:0]) + 10'(s[15:8]) + 10'(s[23:16]) + 10'(s[31:24]);
    fold = 9'(sum[9:8]) + 9'(sum[7:0]);
    return (fold >= 9'd255) ? 8'(fold - 9'd255) : fold[7:0];
  endfunction

  function automatic rgb_t base_color(input pat_t pat, input logic [5:0] i);
    rgb_t c;
    if (pat == PAT_STRIPE) begin
      c = (i[1:0] == 2'd3) ? rgb_t'{8'd255, 8'd80, 8'd0} : rgb_t'{8'd0, 8'd51, 8'd153};
    end else if (i < 6'd8 || i >= 6'd38) begin
      c = rgb_t'{8'd255, 8'd0, 8'd0};
    end else if (i < 6'd14 || i >= 6'd32) begin
      c = rgb_t'{8'd255, 8'd255, 8'd200};
    end else begin
      c = rgb_t'{8'd0, 8'd255, 8'd0};
    end
    return c;
  endfunction

  // brightness index for LED k (or its mirror) at the given volume
  function automatic logic [5:0] end_bright(input logic [3:0] k, input logic [3:0] vol);
    logic [3:0] t;
    logic [3:0] d;
    logic [5:0] m;
    t = 4'd15 - vol;
    d = (t > k) ? t - k : k - t;
    case (d)
      4'd0:    m = 6'd22;
      4'd1:    m = 6'd3;
      4'd2:    m = 6'd2;
      4'd3:    m = 6'd1;
      default: m = 6'd0;
    endcase
    return (k < t) ? m : LAST_IDX - m;
  endfunction

endpackage
`default_nettype wire

@@ rtl/lbm_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lbm_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule
`default_nettype wire

@@ rtl/led_bar_meter_renderer_unit.sv @@
`timescale 1ns / 1ps
// pedal item: accept, multiply on the shared multiplier, write level; then the next item
// render item: per led a load and an output state, plus a multiply and write per channel for
//   the random pattern and again for each of the 30 dimmed end leds, all on the one 32x32
//   multiplier
// one item at a time; in_stall is high while an item is in work
// rst (synchronous) clears enable, level, seed (to one) and the frame timer
`default_nettype none
module led_bar_meter_renderer_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lbm_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lbm_pkg::out_item_t     out_data
);
  import lbm_pkg::*;

  st_t         state, state_next;
  logic        enable;
  logic [15:0] level;
  logic [31:0] seed;
  logic [31:0] last_time;
  logic        rendered;
  pat_t        pat;
  logic [3:0]  vol;
  logic [5:0]  idx;
  logic [1:0]  ch;
  logic [7:0]  chan [3];
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic        in_acc, out_acc;
  logic [19:0] lvl_sum;
  logic [18:0] vol_sum;
  logic [31:0] gap;
  logic        pedal_go, render_go;
  logic        dimmed;
  logic [3:0]  k;
  logic [5:0]  br;
  logic [31:0] lcg_next;
  logic [15:0] dim_val;
  rgb_t        base;

  lbm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign lvl_sum  = ({4'b0, level} << 3) + {4'b0, level} + LVL_TARGET;
  assign vol_sum  = ({3'b0, level} << 2) + {3'b0, level} + 19'd8192;
  assign gap      = in_data.now_ms - last_time;
  assign pedal_go = enable && !in_data.mode && in_data.pedal_byte >= PEDAL_MIN;
  assign render_go = enable && in_data.mode && !(rendered && gap < FRAME_GAP);
  assign dimmed   = idx < 6'(END_LEDS) || idx > (LAST_IDX - 6'(END_LEDS));
  assign k        = (idx < 6'(END_LEDS)) ? idx[3:0] : 4'(LAST_IDX - idx);
  assign br       = end_bright(k, vol);
  assign lcg_next = prod[31:0] + LCG_ADD;
  assign dim_val  = prod[31:16];
  assign base     = base_color(pat, idx);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && pedal_go) state_next = ST_LVL_MUL;
        else if (in_acc && render_go) state_next = ST_PIX;
      end
      ST_LVL_MUL: state_next = ST_LVL_WR;
      ST_LVL_WR:  state_next = ST_IDLE;
      ST_PIX: begin
        if (pat == PAT_RANDOM) state_next = ST_RND_MUL;
        else if (dimmed) state_next = ST_DIM_MUL;
        else state_next = ST_OUT;
      end
      ST_RND_MUL: state_next = ST_RND_ADD;
      ST_RND_ADD: begin
        if (ch != 2'd2) state_next = ST_RND_MUL;
        else if (dimmed) state_next = ST_DIM_MUL;
        else state_next = ST_OUT;
      end
      ST_DIM_MUL: state_next = ST_DIM_WR;
      ST_DIM_WR:  state_next = (ch == 2'd2) ? ST_OUT : ST_DIM_MUL;
      ST_OUT: begin
        if (out_acc) state_next = (idx == LAST_IDX) ? ST_IDLE : ST_PIX;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      ST_IDLE:    in_stall = 1'b0;
      ST_LVL_MUL: begin
        mul_a = {12'b0, lvl_sum};
        mul_b = DIV10_RECIP;
      end
      ST_RND_MUL: begin
        mul_a = seed;
        mul_b = LCG_MUL;
      end
      ST_DIM_MUL: begin
        mul_a = {24'b0, chan[ch]};
        mul_b = {15'b0, tan_q16(br)};
      end
      ST_OUT:     out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_data.led_index = idx;
  assign out_data.red       = chan[0];
  assign out_data.green     = chan[1];
  assign out_data.blue      = chan[2];
  assign out_data.last      = (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      enable    <= 1'b0;
      level     <= '0;
      seed      <= 32'd1;
      last_time <= '0;
      rendered  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) enable <= cfg_data;
      if (state == ST_LVL_WR) level <= prod[38:23];
      if (state == ST_RND_ADD) seed <= lcg_next;
      if (state == ST_IDLE && in_acc && render_go) begin
        last_time <= in_data.now_ms;
        rendered  <= 1'b1;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        idx <= '0;
        vol <= (vol_sum[18:14] > 5'd15) ? 4'd15 : vol_sum[17:14];
        if (in_data.gear == GEAR_STRIPE_A || in_data.gear == GEAR_STRIPE_B)
          pat <= PAT_STRIPE;
        else if (in_data.gear == GEAR_RAND_A || in_data.gear == GEAR_RAND_B)
          pat <= PAT_RANDOM;
        else
          pat <= PAT_BANDS;
      end
      ST_PIX: begin
        ch      <= '0;
        chan[0] <= base.r;
        chan[1] <= base.g;
        chan[2] <= base.b;
      end
      ST_RND_ADD: begin
        chan[ch] <= (ch == 2'd2) ? {2'b0, lcg_next[5:0]} : mod255(lcg_next);
        ch       <= (ch == 2'd2) ? 2'd0 : ch + 2'd1;
      end
      ST_DIM_WR: begin
        chan[ch] <= (dim_val > 16'd255) ? 8'd255 : dim_val[7:0];
        ch       <= (ch == 2'd2) ? 2'd0 : ch + 2'd1;
      end
      ST_OUT: begin
        if (out_acc) idx <= idx + 6'd1;
      end
      default: ;
    endcase
  end

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.led_index == LAST_IDX)
    else $error("last flag away from final led");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.last |=> state == ST_IDLE)
    else $error("frame did not end after final led");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a frame is out");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.led_index <= LAST_IDX)
    else $error("led index out of range");

endmodule
`default_nettype wire
